FILE: src/bass_enhancer_biquad_cascade_defines.svh
// ----------------------------------------------------------------------------
// bass enhancer assertion macros
// shared property templates for the checker, clocked on clk_i and
// disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef BASS_ENHANCER_BIQUAD_CASCADE_DEFINES_SVH
`define BASS_ENHANCER_BIQUAD_CASCADE_DEFINES_SVH

// same-cycle implication
`define BBC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// types, constants and the sequencer microcode of the bass enhancer
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int unsigned ChannelsDef = 8;
  localparam int unsigned SampleW     = 24;
  localparam int unsigned ChanW       = 3;
  localparam int unsigned CoefW       = 32;
  localparam int unsigned GainW       = 16;
  localparam int unsigned HistW       = 32;
  localparam int unsigned HistWords   = 8;
  localparam int unsigned WordW       = 3;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned AccW        = 38;
  localparam int unsigned StepW       = 5;

  localparam logic [StepW-1:0] LastStep    = 5'd27;
  localparam logic [GainW-1:0] BassGainRst = 16'd8192;
  localparam logic [GainW-1:0] InGainRst   = 16'd2048;

  // history word written last for a sample; a row is filled once it lands
  localparam logic [WordW-1:0] HistLastWord = 3'd6;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_LOWPASS_B0  = 3'd0,
    REG_LOWPASS_A1  = 3'd1,
    REG_LOWPASS_A2  = 3'd2,
    REG_HIGHPASS_B0 = 3'd3,
    REG_HIGHPASS_A1 = 3'd4,
    REG_HIGHPASS_A2 = 3'd5,
    REG_BASS_GAIN   = 3'd6,
    REG_INPUT_GAIN  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_in;
    logic [ChanW-1:0]          channel_index;
  } in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_out;
    logic [ChanW-1:0]          channel_out;
  } out_t;

  typedef struct packed {
    logic signed [CoefW-1:0] lp_b0;
    logic signed [CoefW-1:0] lp_a1;
    logic signed [CoefW-1:0] lp_a2;
    logic signed [CoefW-1:0] hp_b0;
    logic signed [CoefW-1:0] hp_a1;
    logic signed [CoefW-1:0] hp_a2;
    logic [GainW-1:0]        bass_gain;
    logic [GainW-1:0]        input_gain;
  } coef_t;

  // control of one multiply-accumulate operation
  typedef struct packed {
    logic sh12;    // round by 12 bits instead of 30
    logic neg;     // subtract the term
    logic dbl;     // double the term
    logic first;   // restart the accumulator
    logic base_s;  // restart from the scaled sample instead of zero
  } mac_ctl_t;

  // history memory request
  typedef struct packed {
    logic                    rd;
    logic [WordW-1:0]        rword;
    logic                    we;
    logic [WordW-1:0]        wword;
    logic signed [HistW-1:0] wdata;
  } hist_req_t;

  typedef enum logic [2:0] {
    C_LB0, C_LA1, C_LA2, C_HB0, C_HA1, C_HA2, C_BASS, C_INGAIN
  } coef_sel_e;

  typedef enum logic [1:0] {
    V_SAMPLE, V_ACC, V_HIST
  } val_sel_e;

  typedef enum logic [2:0] {
    CAP_NONE, CAP_S, CAP_Y1, CAP_Y2, CAP_Y3
  } cap_e;

  typedef enum logic [2:0] {
    W_NONE, W_HIST, W_S, W_Y1, W_Y2, W_Y3
  } wsrc_e;

  typedef struct packed {
    logic             issue;
    coef_sel_e        coef;
    val_sel_e         val;
    logic [WordW-1:0] hidx;
    mac_ctl_t         mac;
    cap_e             cap;
    logic             rd;
    logic [WordW-1:0] rword;
    wsrc_e            wsrc;
    logic [WordW-1:0] wword;
  } uop_t;

  // microcode: one entry per sequencer step
  // history words: 0,1 input; 2,3 first low-pass; 4,5 second low-pass; 6,7 high-pass
  function automatic uop_t uop_decode(input logic [StepW-1:0] step);
    uop_t u;
    u = '0;
    unique case (step)
      // scaled sample, start fetching history
      5'd0: begin
        u.issue = 1'b1; u.coef = C_INGAIN; u.val = V_SAMPLE;
        u.mac.sh12 = 1'b1; u.mac.first = 1'b1;
        u.rd = 1'b1; u.rword = 3'd0;
      end
      5'd1: begin
        u.rd = 1'b1; u.rword = 3'd1;
      end
      5'd2: begin
        u.rd = 1'b1; u.rword = 3'd2;
      end
      // first low-pass
      5'd3: begin
        u.issue = 1'b1; u.coef = C_LB0; u.val = V_ACC;
        u.mac.first = 1'b1; u.cap = CAP_S;
        u.rd = 1'b1; u.rword = 3'd3;
      end
      5'd4: begin
        u.issue = 1'b1; u.coef = C_LB0; u.val = V_HIST; u.hidx = 3'd0;
        u.mac.dbl = 1'b1;
        u.rd = 1'b1; u.rword = 3'd4;
        u.wsrc = W_HIST; u.wword = 3'd1;
      end
      5'd5: begin
        u.issue = 1'b1; u.coef = C_LB0; u.val = V_HIST; u.hidx = 3'd1;
        u.rd = 1'b1; u.rword = 3'd5;
      end
      5'd6: begin
        u.issue = 1'b1; u.coef = C_LA1; u.val = V_HIST; u.hidx = 3'd2;
        u.mac.neg = 1'b1;
        u.rd = 1'b1; u.rword = 3'd6;
        u.wsrc = W_HIST; u.wword = 3'd3;
      end
      5'd7: begin
        u.issue = 1'b1; u.coef = C_LA2; u.val = V_HIST; u.hidx = 3'd3;
        u.mac.neg = 1'b1;
        u.rd = 1'b1; u.rword = 3'd7;
      end
      5'd9: begin
        u.wsrc = W_S; u.wword = 3'd0;
      end
      // second low-pass
      5'd10: begin
        u.issue = 1'b1; u.coef = C_LB0; u.val = V_ACC;
        u.mac.first = 1'b1; u.cap = CAP_Y1;
      end
      5'd11: begin
        u.issue = 1'b1; u.coef = C_LB0; u.val = V_HIST; u.hidx = 3'd2;
        u.mac.dbl = 1'b1;
        u.wsrc = W_Y1; u.wword = 3'd2;
      end
      5'd12: begin
        u.issue = 1'b1; u.coef = C_LB0; u.val = V_HIST; u.hidx = 3'd3;
      end
      5'd13: begin
        u.issue = 1'b1; u.coef = C_LA1; u.val = V_HIST; u.hidx = 3'd4;
        u.mac.neg = 1'b1;
        u.wsrc = W_HIST; u.wword = 3'd5;
      end
      5'd14: begin
        u.issue = 1'b1; u.coef = C_LA2; u.val = V_HIST; u.hidx = 3'd5;
        u.mac.neg = 1'b1;
      end
      // high-pass
      5'd17: begin
        u.issue = 1'b1; u.coef = C_HB0; u.val = V_ACC;
        u.mac.first = 1'b1; u.cap = CAP_Y2;
      end
      5'd18: begin
        u.issue = 1'b1; u.coef = C_HB0; u.val = V_HIST; u.hidx = 3'd4;
        u.mac.neg = 1'b1; u.mac.dbl = 1'b1;
        u.wsrc = W_Y2; u.wword = 3'd4;
      end
      5'd19: begin
        u.issue = 1'b1; u.coef = C_HB0; u.val = V_HIST; u.hidx = 3'd5;
      end
      5'd20: begin
        u.issue = 1'b1; u.coef = C_HA1; u.val = V_HIST; u.hidx = 3'd6;
        u.mac.neg = 1'b1;
        u.wsrc = W_HIST; u.wword = 3'd7;
      end
      5'd21: begin
        u.issue = 1'b1; u.coef = C_HA2; u.val = V_HIST; u.hidx = 3'd7;
        u.mac.neg = 1'b1;
      end
      // bass band gain added onto the scaled sample
      5'd24: begin
        u.issue = 1'b1; u.coef = C_BASS; u.val = V_ACC;
        u.mac.sh12 = 1'b1; u.mac.first = 1'b1; u.mac.base_s = 1'b1;
        u.cap = CAP_Y3;
      end
      5'd25: begin
        u.wsrc = W_Y3; u.wword = HistLastWord;
      end
      default: begin
      end
    endcase
    return u;
  endfunction

endpackage

FILE: src/bbc_hist.sv
// ----------------------------------------------------------------------------
// bbc_hist
// per-channel filter history memory, eight words a channel, one read and
// one write port, a valid bit per channel so unwritten rows read as zero
// ----------------------------------------------------------------------------
module bbc_hist
  import bbc_pkg::*;
#(
  parameter int unsigned CHANNELS = ChannelsDef,
  localparam int unsigned RowW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [RowW-1:0]         row_i,
  input  hist_req_t               req_i,
  output logic signed [HistW-1:0] rdata_o
);

  localparam int unsigned Depth = CHANNELS * HistWords;
  localparam int unsigned AddrW = RowW + WordW;

  logic [HistW-1:0]    mem_q [Depth];
  logic [HistW-1:0]    rdata_q;
  logic                rvalid_q;
  logic [CHANNELS-1:0] valid_q;
  logic [AddrW-1:0]    raddr;
  logic [AddrW-1:0]    waddr;

  assign raddr = {row_i, req_i.rword};
  assign waddr = {row_i, req_i.wword};

  // storage with registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[waddr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_q  <= mem_q[raddr];
      rvalid_q <= valid_q[row_i];
    end
  end

  // row valid bits, cleared by reset, set when word HistLastWord of the row is written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we && (req_i.wword == HistLastWord)) begin
      valid_q[row_i] <= 1'b1;
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

FILE: src/bbc_mac.sv
// ----------------------------------------------------------------------------
// bbc_mac
// shared multiply-accumulate unit: operand register, 32x32 product
// register, then round, scale and accumulate
// ----------------------------------------------------------------------------
module bbc_mac
  import bbc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    issue_i,
  input  mac_ctl_t                ctl_i,
  input  logic signed [CoefW-1:0] coef_i,
  input  logic signed [HistW-1:0] val_i,
  input  logic signed [HistW-1:0] base_i,
  output logic signed [AccW-1:0]  acc_o
);

  logic                    v1_q;
  logic                    v2_q;
  logic signed [CoefW-1:0] a_q;
  logic signed [HistW-1:0] b_q;
  mac_ctl_t                ctl1_q;
  mac_ctl_t                ctl2_q;
  logic signed [63:0]      prod_q;
  logic signed [63:0]      rnd;
  logic signed [AccW-1:0]  term;
  logic signed [AccW-1:0]  dterm;
  logic signed [AccW-1:0]  start;
  logic signed [AccW-1:0]  acc_d;
  logic signed [AccW-1:0]  acc_q;

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= issue_i;
      v2_q <= v1_q;
    end
  end

  // operand and product stages
  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      a_q    <= coef_i;
      b_q    <= val_i;
      ctl1_q <= ctl_i;
    end
    if (v1_q) begin
      prod_q <= 64'(a_q) * 64'(b_q);
      ctl2_q <= ctl1_q;
    end
  end

  // round half up, then add or subtract into the accumulator
  always_comb begin
    rnd   = prod_q + (ctl2_q.sh12 ? 64'sd2048 : 64'sd536870912);
    term  = ctl2_q.sh12 ? AccW'(rnd >>> 12) : AccW'(rnd >>> 30);
    dterm = ctl2_q.dbl ? (term <<< 1) : term;
    if (ctl2_q.first) begin
      start = ctl2_q.base_s ? AccW'(base_i) : '0;
    end else begin
      start = acc_q;
    end
    acc_d = ctl2_q.neg ? (start - dterm) : (start + dterm);
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: src/bbc_seq.sv
// ----------------------------------------------------------------------------
// bbc_seq
// microcoded sequencer: steps one sample through the shared multiply-
// accumulate unit, moves history words and holds the result register
// ----------------------------------------------------------------------------
module bbc_seq
  import bbc_pkg::*;
#(
  parameter int unsigned CHANNELS = ChannelsDef,
  localparam int unsigned RowW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_t                     in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_t                    out_data_o,
  input  coef_t                   coef_i,
  output logic [RowW-1:0]         hist_row_o,
  output hist_req_t               hist_req_o,
  input  logic signed [HistW-1:0] hist_rdata_i,
  output logic                    mac_issue_o,
  output mac_ctl_t                mac_ctl_o,
  output logic signed [CoefW-1:0] mac_coef_o,
  output logic signed [HistW-1:0] mac_val_o,
  output logic signed [HistW-1:0] mac_base_o,
  input  logic signed [AccW-1:0]  mac_acc_i
);

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  localparam logic [5:0] ChanLim = 6'(CHANNELS);
  localparam logic signed [AccW-1:0] Max32 = AccW'(2147483647);
  localparam logic signed [AccW-1:0] Min32 = -Max32 - 1;
  localparam logic signed [AccW-1:0] Max24 = AccW'(8388607);
  localparam logic signed [AccW-1:0] Min24 = -Max24 - 1;

  state_e                    state_q;
  logic [StepW-1:0]          step_q;
  logic                      out_valid_q;
  out_t                      out_q;
  logic signed [SampleW-1:0] sample_q;
  logic [ChanW-1:0]          chan_q;
  logic                      filt_en_q;
  logic signed [HistW-1:0]   s_q;
  logic signed [HistW-1:0]   y1_q;
  logic signed [HistW-1:0]   y2_q;
  logic signed [HistW-1:0]   y3_q;
  logic signed [HistW-1:0]   hreg_q [HistWords];
  logic                      rd_v_q;
  logic [WordW-1:0]          rd_word_q;
  uop_t                      u;
  logic                      run;
  logic                      out_free;
  logic                      finish;
  logic signed [HistW-1:0]   acc_sat;
  logic signed [HistW-1:0]   hist_val;
  logic signed [HistW-1:0]   wdata;

  function automatic logic signed [HistW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] r;
    priority if (v > Max32) r = Max32;
    else if (v < Min32)     r = Min32;
    else                    r = v;
    return HistW'(r);
  endfunction

  function automatic logic signed [SampleW-1:0] sat24(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] r;
    priority if (v > Max24) r = Max24;
    else if (v < Min24)     r = Min24;
    else                    r = v;
    return SampleW'(r);
  endfunction

  assign u        = uop_decode(step_q);
  assign run      = (state_q == ST_RUN);
  assign out_free = !out_valid_q || !out_stall_i;
  assign finish   = run && (step_q == LastStep) && out_free;
  assign acc_sat  = sat32(mac_acc_i);
  assign hist_val = hreg_q[u.hidx];

  // sequencer state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // load a finished sample, else release a taken result
      if (finish) begin
        out_valid_q       <= 1'b1;
        out_q.sample_out  <= sat24(mac_acc_i);
        out_q.channel_out <= chan_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_RUN;
            step_q  <= '0;
          end
        end
        ST_RUN: begin
          if (finish) begin
            state_q <= ST_IDLE;
          end else if (step_q != LastStep) begin
            step_q <= step_q + StepW'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // take the request
  always_ff @(posedge clk_i) begin
    if (!run && in_valid_i) begin
      sample_q  <= in_data_i.sample_in;
      chan_q    <= in_data_i.channel_index;
      filt_en_q <= ({3'b000, in_data_i.channel_index} < ChanLim);
    end
  end

  // capture stage results off the accumulator
  always_ff @(posedge clk_i) begin
    if (run) begin
      unique case (u.cap)
        CAP_NONE: begin
        end
        CAP_S:  s_q  <= acc_sat;
        CAP_Y1: y1_q <= acc_sat;
        CAP_Y2: y2_q <= acc_sat;
        CAP_Y3: y3_q <= acc_sat;
        default: begin
        end
      endcase
    end
  end

  // history read return
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= hist_req_o.rd;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_word_q <= u.rword;
    if (rd_v_q) begin
      hreg_q[rd_word_q] <= hist_rdata_i;
    end
  end

  // coefficient operand; bass term is dropped for unfiltered channels
  always_comb begin
    unique case (u.coef)
      C_LB0:    mac_coef_o = coef_i.lp_b0;
      C_LA1:    mac_coef_o = coef_i.lp_a1;
      C_LA2:    mac_coef_o = coef_i.lp_a2;
      C_HB0:    mac_coef_o = coef_i.hp_b0;
      C_HA1:    mac_coef_o = coef_i.hp_a1;
      C_HA2:    mac_coef_o = coef_i.hp_a2;
      C_BASS:   mac_coef_o = filt_en_q ? {16'h0000, coef_i.bass_gain} : '0;
      C_INGAIN: mac_coef_o = {16'h0000, coef_i.input_gain};
      default:  mac_coef_o = '0;
    endcase
  end

  // value operand
  always_comb begin
    unique case (u.val)
      V_SAMPLE: mac_val_o = HistW'(sample_q);
      V_ACC:    mac_val_o = acc_sat;
      V_HIST:   mac_val_o = hist_val;
      default:  mac_val_o = '0;
    endcase
  end

  // history write data
  always_comb begin
    unique case (u.wsrc)
      W_HIST:  wdata = hist_val;
      W_S:     wdata = s_q;
      W_Y1:    wdata = y1_q;
      W_Y2:    wdata = y2_q;
      W_Y3:    wdata = y3_q;
      default: wdata = '0;
    endcase
  end

  assign mac_issue_o = run && u.issue;
  assign mac_ctl_o   = u.mac;
  assign mac_base_o  = s_q;

  assign hist_row_o       = RowW'(chan_q);
  assign hist_req_o.rd    = run && u.rd && filt_en_q;
  assign hist_req_o.rword = u.rword;
  assign hist_req_o.we    = run && (u.wsrc != W_NONE) && filt_en_q;
  assign hist_req_o.wword = u.wword;
  assign hist_req_o.wdata = wdata;

  assign in_stall_o  = run;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/bass_enhancer_biquad_cascade.sv
// ----------------------------------------------------------------------------
// bass_enhancer_biquad_cascade
// Bass enhancer for interleaved audio: each request carries a Q1.23 sample
// and a channel index. The sample is scaled by the input gain, run through
// two identical low-pass biquads and one high-pass biquad (direct form I,
// history kept per channel), the filtered band is scaled by the bass gain
// and added back to the scaled sample, and the sum is saturated to 24 bits.
// The result is loaded into the output register at the last sequencer step,
// and the next request is taken only once the block is idle again after
// that, so a sample occupies the idle cycle in which its request is taken
// and 28 steps of a microcode sequencer that drives a single shared 32x32
// multiply-accumulate unit through its 17 products; the three-stage pipeline
// of that unit between dependent filter stages sets the length. Input stall
// is high during those steps and for as long as a finished result cannot
// move into a still-occupied output register. A channel index at or above
// CHANNELS gives the scaled sample alone and leaves all history untouched.
// History starts at zero after reset with no clearing pass. Coefficients
// are Q2.30, gains unsigned Q4.12; the reset register values make the block
// a plain 0.5x pass-through with 2.0 bass.
// ----------------------------------------------------------------------------
module bass_enhancer_biquad_cascade
  import bbc_pkg::*;
#(
  parameter int unsigned CHANNELS = ChannelsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoefW-1:0]   cfg_data_i
);

  localparam int unsigned RowW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  coef_t                   cfg_q;
  logic [RowW-1:0]         hist_row;
  hist_req_t               hist_req;
  logic signed [HistW-1:0] hist_rdata;
  logic                    mac_issue;
  mac_ctl_t                mac_ctl;
  logic signed [CoefW-1:0] mac_coef;
  logic signed [HistW-1:0] mac_val;
  logic signed [HistW-1:0] mac_base;
  logic signed [AccW-1:0]  mac_acc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lp_b0      <= '0;
      cfg_q.lp_a1      <= '0;
      cfg_q.lp_a2      <= '0;
      cfg_q.hp_b0      <= '0;
      cfg_q.hp_a1      <= '0;
      cfg_q.hp_a2      <= '0;
      cfg_q.bass_gain  <= BassGainRst;
      cfg_q.input_gain <= InGainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOWPASS_B0:  cfg_q.lp_b0      <= cfg_data_i;
        REG_LOWPASS_A1:  cfg_q.lp_a1      <= cfg_data_i;
        REG_LOWPASS_A2:  cfg_q.lp_a2      <= cfg_data_i;
        REG_HIGHPASS_B0: cfg_q.hp_b0      <= cfg_data_i;
        REG_HIGHPASS_A1: cfg_q.hp_a1      <= cfg_data_i;
        REG_HIGHPASS_A2: cfg_q.hp_a2      <= cfg_data_i;
        REG_BASS_GAIN:   cfg_q.bass_gain  <= cfg_data_i[GainW-1:0];
        REG_INPUT_GAIN:  cfg_q.input_gain <= cfg_data_i[GainW-1:0];
        default: begin
        end
      endcase
    end
  end

  bbc_seq #(
    .CHANNELS (CHANNELS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .coef_i       (cfg_q),
    .hist_row_o   (hist_row),
    .hist_req_o   (hist_req),
    .hist_rdata_i (hist_rdata),
    .mac_issue_o  (mac_issue),
    .mac_ctl_o    (mac_ctl),
    .mac_coef_o   (mac_coef),
    .mac_val_o    (mac_val),
    .mac_base_o   (mac_base),
    .mac_acc_i    (mac_acc)
  );

  bbc_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (mac_issue),
    .ctl_i   (mac_ctl),
    .coef_i  (mac_coef),
    .val_i   (mac_val),
    .base_i  (mac_base),
    .acc_o   (mac_acc)
  );

  bbc_hist #(
    .CHANNELS (CHANNELS)
  ) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .row_i   (hist_row),
    .req_i   (hist_req),
    .rdata_o (hist_rdata)
  );

endmodule

FILE: src/bbc_chk.sv
// ----------------------------------------------------------------------------
// bbc_chk
// port-level checks of the bass enhancer, bound to the top level
// ----------------------------------------------------------------------------
`include "bass_enhancer_biquad_cascade_defines.svh"

module bbc_chk
  import bbc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // a taken request keeps the block busy for the following cycles
  `BBC_ASSERT_NXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o, "not busy after request")
  `BBC_ASSERT_IMP(a_busy_two_cycles, in_valid_i && !in_stall_o, ##2 in_stall_o, "busy ended early")

  // a new result only comes out of a running computation
  `BBC_ASSERT_IMP(a_result_from_work, $rose(out_valid_o), $past(in_stall_o), "result while idle")

  // a stalled result holds
  `BBC_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

endmodule

bind bass_enhancer_biquad_cascade bbc_chk u_bbc_chk (.*);
